// ===== design/cgd_pkg.sv =====
// Shared types and constants for the crank gap decoder and edge scheduler.
// Holds the request/result payload structs, result kind codes and register defaults.
// No dependencies.
`timescale 1ns / 1ps

package cgd_pkg;

    // Wheel geometry: crank degrees covered by one tooth
    localparam int unsigned DEGREES_PER_TOOTH = 6;

    // Request type codes
    localparam logic REQ_CAPTURE  = 1'b0;
    localparam logic REQ_OVERFLOW = 1'b1;

    // Result kind codes
    localparam logic [1:0] KIND_RATE = 2'd0;
    localparam logic [1:0] KIND_EDGE = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    // Output channel of the final scheduled edge (injectors 2 and 3)
    localparam logic [1:0] CH_INJ_B = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_CORE_CLOCK  = 3'd0;
    localparam logic [2:0] CFG_OVF_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_COIL_DWELL  = 3'd2;
    localparam logic [2:0] CFG_FIRST_TDC   = 3'd3;
    localparam logic [2:0] CFG_SECOND_TDC  = 3'd4;

    // Configuration reset values
    localparam logic [31:0] CORE_CLOCK_RESET = 32'd64000000;
    localparam logic [15:0] OVF_LIMIT_RESET  = 16'd97;
    localparam logic [31:0] COIL_DWELL_RESET = 32'd192000;
    localparam logic [5:0]  FIRST_TDC_RESET  = 6'd20;
    localparam logic [5:0]  SECOND_TDC_RESET = 6'd52;

    // One incoming request
    typedef struct packed {
        logic        req_type;
        logic [15:0] capture_ticks;
        logic [7:0]  advance_deg;
        logic [31:0] inj_pulse_ticks;
        logic [31:0] inj_lead_ticks;
    } cgd_req_t;

    // One result
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tooth_rate;
        logic [31:0] delay_ticks;
        logic [1:0]  channel;
        logic        level_off;
        logic        restarted;
        logic        last;
    } cgd_rsp_t;

endpackage

// ===== design/crank_gap_decoder_scheduler_core.sv =====
// Top level of the 60-minus-2 crank gap decoder and coil/injector edge scheduler.
// Depends on cgd_pkg (payload structs, kind codes, register defaults).
// Built around a bit-serial restoring divider and a shift-add multiplier.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall / req_data): tooth captures and timer
//   overflows. A request is taken when req_valid is high and req_stall is low.
//   Result channel (rsp_valid / rsp_stall / rsp_data): rate updates, stop reports
//   and, on the gap, eight scheduled edges in fixed order, last flagged.
//   Config port (cfg_we / cfg_index / cfg_wdata): write while the block is idle.
// Work per request
//   Overflow request: counted as it is taken; a stop report also passes through ST_EMIT1.
//   Ordinary tooth: setup (ST_CHK, ST_SUM7, ST_TEST), 32 divide steps, rate, result.
//   Gap tooth: rate divide (32 steps), period / degrees-per-tooth divide
//   (32 steps), three 8-step multiplies, then one edge per cycle while the output is free.
//   The divider is one-bit-per-cycle; one request is in work at a time and
//   req_stall stays high until its results are all loaded.
// Reset
//   rst_n clears sync, the overflow count and both periods, and loads the
//   register defaults.
// Stall
//   A held result waits in the output register; the next request is still taken
//   and worked on, and its first result waits for the register to free up.

module crank_gap_decoder_scheduler_core #(
    parameter int unsigned DEGREES_PER_TOOTH = cgd_pkg::DEGREES_PER_TOOTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  cgd_pkg::cgd_req_t  req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output cgd_pkg::cgd_rsp_t  rsp_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CHK      = 4'd1;
    localparam logic [3:0] ST_SUM7     = 4'd2;
    localparam logic [3:0] ST_TEST     = 4'd3;
    localparam logic [3:0] ST_DIV_RATE = 4'd4;
    localparam logic [3:0] ST_RATE     = 4'd5;
    localparam logic [3:0] ST_DIV_ADV  = 4'd6;
    localparam logic [3:0] ST_MUL      = 4'd7;
    localparam logic [3:0] ST_IGN      = 4'd8;
    localparam logic [3:0] ST_EMIT1    = 4'd9;
    localparam logic [3:0] ST_EMIT8    = 4'd10;

    // Multiply job codes
    localparam logic [1:0] MUL_TDC_A = 2'd0;
    localparam logic [1:0] MUL_TDC_B = 2'd1;
    localparam logic [1:0] MUL_ADV   = 2'd2;

    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
    localparam int MUL_W     = 8;
    localparam int MUL_CNT_W = $clog2(MUL_W);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_W - 1);
    localparam logic [2:0] EMIT_LAST = 3'd7;

    // Configuration registers
    logic [31:0] core_clock_reg, core_clock_next;
    logic [15:0] ovf_limit_reg, ovf_limit_next;
    logic [31:0] coil_dwell_reg, coil_dwell_next;
    logic [5:0]  first_tdc_reg, first_tdc_next;
    logic [5:0]  second_tdc_reg, second_tdc_next;

    // Control and decoder state
    logic [3:0]  state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [15:0] ovf_count_reg, ovf_count_next;
    logic [31:0] older_reg, older_next;
    logic [31:0] newest_reg, newest_next;
    logic        in_sync_reg, in_sync_next;
    logic        gap_reg, gap_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [1:0]  mul_sel_reg, mul_sel_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;

    // Datapath registers
    cgd_pkg::cgd_req_t req_hold_reg, req_hold_next;
    cgd_pkg::cgd_rsp_t rsp_data_reg, rsp_data_next;
    logic [34:0] o5_reg, o5_next;
    logic [34:0] o7_reg, o7_next;
    logic        rs_reg, rs_next;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [31:0] div_dq_reg, div_dq_next;
    logic [31:0] div_dvs_reg, div_dvs_next;
    logic [31:0] mul_acc_reg, mul_acc_next;
    logic [31:0] mul_mcand_reg, mul_mcand_next;
    logic [MUL_W-1:0] mul_mplier_reg, mul_mplier_next;
    logic [31:0] tdc_a_reg, tdc_a_next;
    logic [31:0] tdc_b_reg, tdc_b_next;
    logic [31:0] ign_a_reg, ign_a_next;
    logic [31:0] ign_b_reg, ign_b_next;
    logic [15:0] rate_reg, rate_next;
    logic [1:0]  emit_kind_reg, emit_kind_next;

    // Helpers
    logic        out_free;
    logic [15:0] ovf_inc;
    logic [31:0] period_new;
    logic [34:0] n2;
    logic [33:0] div_diff;
    logic        div_borrow;
    logic [31:0] div_rem_step;
    logic [31:0] div_dq_step;
    logic [31:0] mul_acc_step;
    logic [31:0] emit_ign;
    logic [31:0] emit_tdc;
    logic [31:0] emit_delay;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Overflow count, saturating
    assign ovf_inc = (ovf_count_reg != 16'hFFFF) ? ovf_count_reg + 16'd1 : ovf_count_reg;

    // Period = capture + 65535 * overflows, written as (count << 16) - count + capture
    assign period_new = {ovf_count_reg, 16'h0000} - {16'h0000, ovf_count_reg}
                      + {16'h0000, req_data.capture_ticks};

    assign n2 = {2'b00, newest_reg, 1'b0};

    // One restoring divide step: shift in the next dividend bit, trial subtract
    assign div_diff     = {1'b0, div_rem_reg, div_dq_reg[31]} - {2'b00, div_dvs_reg};
    assign div_borrow   = div_diff[33];
    assign div_rem_step = div_borrow ? {div_rem_reg[30:0], div_dq_reg[31]} : div_diff[31:0];
    assign div_dq_step  = {div_dq_reg[30:0], !div_borrow};

    // One shift-add multiply step
    assign mul_acc_step = mul_acc_reg + (mul_mplier_reg[0] ? mul_mcand_reg : 32'd0);

    // Scheduled edge time: index bit 2 picks the cylinder pair, bits 1:0 the edge
    assign emit_ign = emit_idx_reg[2] ? ign_b_reg : ign_a_reg;
    assign emit_tdc = emit_idx_reg[2] ? tdc_b_reg : tdc_a_reg;

    always_comb
    begin
        unique case (emit_idx_reg[1:0])
            2'd0:    emit_delay = emit_ign - coil_dwell_reg;
            2'd1:    emit_delay = emit_ign;
            2'd2:    emit_delay = emit_tdc - req_hold_reg.inj_lead_ticks;
            default: emit_delay = emit_tdc + req_hold_reg.inj_pulse_ticks;
        endcase
    end

    // Configuration writes
    always_comb
    begin
        core_clock_next = core_clock_reg;
        ovf_limit_next  = ovf_limit_reg;
        coil_dwell_next = coil_dwell_reg;
        first_tdc_next  = first_tdc_reg;
        second_tdc_next = second_tdc_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cgd_pkg::CFG_CORE_CLOCK: core_clock_next = cfg_wdata;
                cgd_pkg::CFG_OVF_LIMIT:  ovf_limit_next  = cfg_wdata[15:0];
                cgd_pkg::CFG_COIL_DWELL: coil_dwell_next = cfg_wdata;
                cgd_pkg::CFG_FIRST_TDC:  first_tdc_next  = cfg_wdata[5:0];
                cgd_pkg::CFG_SECOND_TDC: second_tdc_next = cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        ovf_count_next  = ovf_count_reg;
        older_next      = older_reg;
        newest_next     = newest_reg;
        in_sync_next    = in_sync_reg;
        gap_next        = gap_reg;
        div_cnt_next    = div_cnt_reg;
        mul_cnt_next    = mul_cnt_reg;
        mul_sel_next    = mul_sel_reg;
        emit_idx_next   = emit_idx_reg;
        req_hold_next   = req_hold_reg;
        rsp_data_next   = rsp_data_reg;
        o5_next         = o5_reg;
        o7_next         = o7_reg;
        rs_next         = rs_reg;
        div_rem_next    = div_rem_reg;
        div_dq_next     = div_dq_reg;
        div_dvs_next    = div_dvs_reg;
        mul_acc_next    = mul_acc_reg;
        mul_mcand_next  = mul_mcand_reg;
        mul_mplier_next = mul_mplier_reg;
        tdc_a_next      = tdc_a_reg;
        tdc_b_next      = tdc_b_reg;
        ign_a_next      = ign_a_reg;
        ign_b_next      = ign_b_reg;
        rate_next       = rate_reg;
        emit_kind_next  = emit_kind_reg;

        // Output register drains when taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_hold_next = req_data;
                    if (req_data.req_type == cgd_pkg::REQ_OVERFLOW)
                    begin
                        if (ovf_inc > ovf_limit_reg)
                        begin
                            // Engine stopped: drop sync and history
                            ovf_count_next = 16'd0;
                            older_next     = 32'd0;
                            newest_next    = 32'd0;
                            in_sync_next   = 1'b0;
                            emit_kind_next = cgd_pkg::KIND_STOP;
                            state_next     = ST_EMIT1;
                        end
                        else
                        begin
                            ovf_count_next = ovf_inc;
                        end
                    end
                    else
                    begin
                        older_next     = newest_reg;
                        newest_next    = period_new;
                        ovf_count_next = 16'd0;
                        state_next     = ST_CHK;
                    end
                end
            end

            ST_CHK:
            begin
                if (older_reg == 32'd0 || newest_reg == 32'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    o5_next    = {1'b0, older_reg, 2'b00} + {3'b000, older_reg};
                    state_next = ST_SUM7;
                end
            end

            ST_SUM7:
            begin
                o7_next    = o5_reg + {2'b00, older_reg, 1'b0};
                state_next = ST_TEST;
            end

            // Gap test and start of the tooth rate divide
            ST_TEST:
            begin
                gap_next     = (n2 >= o5_reg) && (n2 < o7_reg);
                div_dq_next  = core_clock_reg;
                div_rem_next = 32'd0;
                div_cnt_next = '0;
                if ((n2 >= o5_reg) && (n2 < o7_reg))
                begin
                    div_dvs_next = older_reg;
                    rs_next      = !in_sync_reg;
                    in_sync_next = 1'b1;
                end
                else
                begin
                    div_dvs_next = newest_reg;
                end
                state_next = ST_DIV_RATE;
            end

            ST_DIV_RATE:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_RATE;
                end
            end

            // Saturate the rate; on the gap start period / degrees-per-tooth
            ST_RATE:
            begin
                rate_next = (div_dq_reg[31:16] != 16'h0000) ? 16'hFFFF : div_dq_reg[15:0];
                if (gap_reg)
                begin
                    div_dq_next  = older_reg;
                    div_rem_next = 32'd0;
                    div_dvs_next = 32'(DEGREES_PER_TOOTH);
                    div_cnt_next = '0;
                    state_next   = ST_DIV_ADV;
                end
                else
                begin
                    emit_kind_next = cgd_pkg::KIND_RATE;
                    state_next     = ST_EMIT1;
                end
            end

            ST_DIV_ADV:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    mul_acc_next    = 32'd0;
                    mul_mcand_next  = older_reg;
                    mul_mplier_next = MUL_W'(first_tdc_reg);
                    mul_cnt_next    = '0;
                    mul_sel_next    = MUL_TDC_A;
                    state_next      = ST_MUL;
                end
            end

            // Three multiplies in turn: tdcA, tdcB, then advance ticks
            ST_MUL:
            begin
                mul_acc_next    = mul_acc_step;
                mul_mcand_next  = {mul_mcand_reg[30:0], 1'b0};
                mul_mplier_next = {1'b0, mul_mplier_reg[MUL_W-1:1]};
                mul_cnt_next    = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MUL_LAST)
                begin
                    mul_cnt_next = '0;
                    unique case (mul_sel_reg)
                        MUL_TDC_A:
                        begin
                            tdc_a_next      = mul_acc_step;
                            mul_acc_next    = 32'd0;
                            mul_mcand_next  = older_reg;
                            mul_mplier_next = MUL_W'(second_tdc_reg);
                            mul_sel_next    = MUL_TDC_B;
                        end
                        MUL_TDC_B:
                        begin
                            tdc_b_next      = mul_acc_step;
                            mul_acc_next    = 32'd0;
                            mul_mcand_next  = div_dq_reg;
                            mul_mplier_next = req_hold_reg.advance_deg;
                            mul_sel_next    = MUL_ADV;
                        end
                        default:
                        begin
                            state_next = ST_IGN;
                        end
                    endcase
                end
            end

            ST_IGN:
            begin
                ign_a_next    = tdc_a_reg - mul_acc_reg;
                ign_b_next    = tdc_b_reg - mul_acc_reg;
                emit_idx_next = 3'd0;
                state_next    = ST_EMIT8;
            end

            // Single result: rate update or stop report
            ST_EMIT1:
            begin
                if (out_free)
                begin
                    rsp_data_next      = '0;
                    rsp_data_next.kind = emit_kind_reg;
                    rsp_data_next.tooth_rate =
                        (emit_kind_reg == cgd_pkg::KIND_STOP) ? 16'd0 : rate_reg;
                    rsp_data_next.last = 1'b1;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            // Eight scheduled edges; channel is the edge index over two
            ST_EMIT8:
            begin
                if (out_free)
                begin
                    rsp_data_next.kind        = cgd_pkg::KIND_EDGE;
                    rsp_data_next.tooth_rate  = rate_reg;
                    rsp_data_next.delay_ticks = emit_delay;
                    rsp_data_next.channel     = emit_idx_reg[2:1];
                    rsp_data_next.level_off   = emit_idx_reg[0];
                    rsp_data_next.restarted   = rs_reg;
                    rsp_data_next.last        = (emit_idx_reg == EMIT_LAST);
                    rsp_valid_next            = 1'b1;
                    emit_idx_next             = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == EMIT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_clock_reg <= cgd_pkg::CORE_CLOCK_RESET;
            ovf_limit_reg  <= cgd_pkg::OVF_LIMIT_RESET;
            coil_dwell_reg <= cgd_pkg::COIL_DWELL_RESET;
            first_tdc_reg  <= cgd_pkg::FIRST_TDC_RESET;
            second_tdc_reg <= cgd_pkg::SECOND_TDC_RESET;
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            ovf_count_reg  <= 16'd0;
            older_reg      <= 32'd0;
            newest_reg     <= 32'd0;
            in_sync_reg    <= 1'b0;
            gap_reg        <= 1'b0;
            div_cnt_reg    <= '0;
            mul_cnt_reg    <= '0;
            mul_sel_reg    <= MUL_TDC_A;
            emit_idx_reg   <= 3'd0;
        end
        else
        begin
            core_clock_reg <= core_clock_next;
            ovf_limit_reg  <= ovf_limit_next;
            coil_dwell_reg <= coil_dwell_next;
            first_tdc_reg  <= first_tdc_next;
            second_tdc_reg <= second_tdc_next;
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            ovf_count_reg  <= ovf_count_next;
            older_reg      <= older_next;
            newest_reg     <= newest_next;
            in_sync_reg    <= in_sync_next;
            gap_reg        <= gap_next;
            div_cnt_reg    <= div_cnt_next;
            mul_cnt_reg    <= mul_cnt_next;
            mul_sel_reg    <= mul_sel_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        req_hold_reg   <= req_hold_next;
        rsp_data_reg   <= rsp_data_next;
        o5_reg         <= o5_next;
        o7_reg         <= o7_next;
        rs_reg         <= rs_next;
        div_rem_reg    <= div_rem_next;
        div_dq_reg     <= div_dq_next;
        div_dvs_reg    <= div_dvs_next;
        mul_acc_reg    <= mul_acc_next;
        mul_mcand_reg  <= mul_mcand_next;
        mul_mplier_reg <= mul_mplier_next;
        tdc_a_reg      <= tdc_a_next;
        tdc_b_reg      <= tdc_b_next;
        ign_a_reg      <= ign_a_next;
        ign_b_reg      <= ign_b_next;
        rate_reg       <= rate_next;
        emit_kind_reg  <= emit_kind_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // An accepted capture request starts the sequencer, so req_stall is high in the following cycle
    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_data.req_type == cgd_pkg::REQ_CAPTURE) |=> req_stall)
        else $error("capture request did not start the sequencer");

    // The divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RATE || state_reg == ST_DIV_ADV) |-> (div_dvs_reg != 32'd0))
        else $error("divide step with zero divisor");

    // The final scheduled edge is the injector 2/3 off edge
    a_last_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.kind == cgd_pkg::KIND_EDGE && rsp_data.last)
            |-> (rsp_data.channel == cgd_pkg::CH_INJ_B && rsp_data.level_off))
        else $error("last scheduled edge on wrong channel or level");

    // A stop report carries no rate and ends its request
    a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.kind == cgd_pkg::KIND_STOP)
            |-> (rsp_data.tooth_rate == 16'd0 && rsp_data.last))
        else $error("malformed stop report");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for crank_gap_decoder_scheduler_core: wheel tooth streams,
// overflow bursts and register changes, results checked against an in-bench predictor.
// Depends on cgd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
    import cgd_pkg::*;

    // Result channel codes and drive levels used by the edge schedule
    localparam logic [1:0] CH_COIL_A = 2'd0;
    localparam logic [1:0] CH_INJ_A  = 2'd1;
    localparam logic [1:0] CH_COIL_B = 2'd2;
    localparam logic       LEVEL_ON  = 1'b0;
    localparam logic       LEVEL_OFF = 1'b1;

    // Quiet time before a register write, and the watchdog limit
    localparam int LATENCY_GUARD = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 57;
    localparam int OPENING_ITEMS = 24;

    // Tracks the decoder state and the queue of results still owed by the block
    class gap_schedule_board;
        logic [31:0] clock_hz;
        logic [15:0] stop_limit;
        logic [31:0] dwell;
        logic [5:0]  tdc_first;
        logic [5:0]  tdc_second;
        logic [15:0] ovf_count;
        logic [31:0] prev_period;
        logic [31:0] last_period;
        logic        synced;
        cgd_rsp_t    awaited[$];
        int          errors = 0;
        int          n_checked = 0;
        int          n_bursts = 0;
        int          n_rates = 0;
        int          n_stops = 0;

        function new();
            clock_hz    = CORE_CLOCK_RESET;
            stop_limit  = OVF_LIMIT_RESET;
            dwell       = COIL_DWELL_RESET;
            tdc_first   = FIRST_TDC_RESET;
            tdc_second  = SECOND_TDC_RESET;
            ovf_count   = '0;
            prev_period = '0;
            last_period = '0;
            synced      = 1'b0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_CORE_CLOCK: clock_hz   = val;
                CFG_OVF_LIMIT:  stop_limit = val[15:0];
                CFG_COIL_DWELL: dwell      = val;
                CFG_FIRST_TDC:  tdc_first  = val[5:0];
                CFG_SECOND_TDC: tdc_second = val[5:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // clock / period, saturated to 16 bits; zero period gives zero
        function logic [15:0] rate_for(logic [31:0] period);
            logic [31:0] q;
            if (period == 0)
                return '0;
            q = clock_hz / period;
            return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
        endfunction

        function void queue_result(logic [1:0] kind, logic [15:0] rate, logic [31:0] delay,
                                   logic [1:0] ch, logic off, logic rs, logic last);
            cgd_rsp_t r;
            r.kind        = kind;
            r.tooth_rate  = rate;
            r.delay_ticks = delay;
            r.channel     = ch;
            r.level_off   = off;
            r.restarted   = rs;
            r.last        = last;
            awaited.push_back(r);
        endfunction

        function void note_request(cgd_req_t r);
            logic [35:0] twice_new;
            logic [35:0] lo_bound;
            logic [35:0] hi_bound;
            logic [31:0] p;
            logic [31:0] tdc_a;
            logic [31:0] tdc_b;
            logic [31:0] adv;
            logic [31:0] ign_a;
            logic [31:0] ign_b;
            logic [15:0] rate;
            logic        rs;

            // overflow: count, and declare a stop once past the limit
            if (r.req_type == REQ_OVERFLOW)
            begin
                if (ovf_count != 16'hFFFF)
                    ovf_count++;
                if (ovf_count > stop_limit)
                begin
                    ovf_count   = '0;
                    prev_period = '0;
                    last_period = '0;
                    synced      = 1'b0;
                    queue_result(KIND_STOP, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                    n_stops++;
                end
                return;
            end

            // capture: build the period from the count of wraps
            prev_period = last_period;
            last_period = {16'h0, r.capture_ticks} + 32'hFFFF * {16'h0, ovf_count};
            ovf_count   = '0;
            if (prev_period == 0 || last_period == 0)
                return;

            twice_new = {3'b000, last_period, 1'b0};
            lo_bound  = {4'h0, prev_period};
            hi_bound  = lo_bound * 7;
            lo_bound  = lo_bound * 5;
            if (twice_new >= lo_bound && twice_new < hi_bound)
            begin
                // gap found: queue eight scheduled results, timed from the gap
                p      = prev_period;
                rate   = rate_for(p);
                rs     = !synced;
                tdc_a  = p * tdc_first;
                tdc_b  = p * tdc_second;
                adv    = (p / DEGREES_PER_TOOTH) * r.advance_deg;
                ign_a  = tdc_a - adv;
                ign_b  = tdc_b - adv;
                synced = 1'b1;
                queue_result(KIND_EDGE, rate, ign_a - dwell, CH_COIL_A, LEVEL_ON, rs, 1'b0);
                queue_result(KIND_EDGE, rate, ign_a, CH_COIL_A, LEVEL_OFF, rs, 1'b0);
                queue_result(KIND_EDGE, rate, tdc_a - r.inj_lead_ticks, CH_INJ_A, LEVEL_ON,
                             rs, 1'b0);
                queue_result(KIND_EDGE, rate, tdc_a + r.inj_pulse_ticks, CH_INJ_A, LEVEL_OFF,
                             rs, 1'b0);
                queue_result(KIND_EDGE, rate, ign_b - dwell, CH_COIL_B, LEVEL_ON, rs, 1'b0);
                queue_result(KIND_EDGE, rate, ign_b, CH_COIL_B, LEVEL_OFF, rs, 1'b0);
                queue_result(KIND_EDGE, rate, tdc_b - r.inj_lead_ticks, CH_INJ_B, LEVEL_ON,
                             rs, 1'b0);
                queue_result(KIND_EDGE, rate, tdc_b + r.inj_pulse_ticks, CH_INJ_B, LEVEL_OFF,
                             rs, 1'b1);
                n_bursts++;
            end
            else
            begin
                queue_result(KIND_RATE, rate_for(last_period), '0, '0, 1'b0, 1'b0, 1'b1);
                n_rates++;
            end
        endfunction

        task report_mismatch(string field, logic [31:0] seen, logic [31:0] wanted);
            errors++;
            $display("mismatch on result %0d: %s is 0x%0h, should be 0x%0h",
                     n_checked, field, seen, wanted);
        endtask

        task check_result(cgd_rsp_t got);
            cgd_rsp_t want;
            n_checked++;
            if (awaited.size() == 0)
            begin
                report_mismatch("kind (no result owed)", 32'(got.kind), 32'd0);
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.tooth_rate !== want.tooth_rate)
                report_mismatch("tooth_rate", 32'(got.tooth_rate), 32'(want.tooth_rate));
            if (got.delay_ticks !== want.delay_ticks)
                report_mismatch("delay_ticks", got.delay_ticks, want.delay_ticks);
            if (got.channel !== want.channel)
                report_mismatch("channel", 32'(got.channel), 32'(want.channel));
            if (got.level_off !== want.level_off)
                report_mismatch("level_off", 32'(got.level_off), 32'(want.level_off));
            if (got.restarted !== want.restarted)
                report_mismatch("restarted", 32'(got.restarted), 32'(want.restarted));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    cgd_req_t    req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    cgd_rsp_t    rsp_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_CORE_CLOCK;
    logic [31:0] cfg_wdata = '0;

    gap_schedule_board board;
    int n_sent = 0;
    int n_results = 0;
    int idle_cycles = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    crank_gap_decoder_scheduler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: ends the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic cgd_req_t pack_req(logic t, logic [15:0] cap, logic [7:0] adv,
                                          logic [31:0] pulse, logic [31:0] lead);
        cgd_req_t r;
        r.req_type        = t;
        r.capture_ticks   = cap;
        r.advance_deg     = adv;
        r.inj_pulse_ticks = pulse;
        r.inj_lead_ticks  = lead;
        return r;
    endfunction

    function automatic cgd_req_t random_req(logic t);
        return pack_req(t, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                        $urandom, $urandom);
    endfunction

    // Offer one request with a random lead-in gap, wait for it to be taken
    task automatic send_req(input cgd_req_t r);
        int gap;
        if (n_sent % 32 == 0)
            quiet_tx = ($urandom_range(0, 3) == 0);
        gap = quiet_tx ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_data  <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall !== 1'b0);
        board.note_request(r);
        n_sent++;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [31:0] clk_hz, input logic [31:0] limit,
                                input logic [31:0] dwell, input logic [31:0] tdc1,
                                input logic [31:0] tdc2);
        wait_drained();
        repeat (LATENCY_GUARD) @(posedge clk);
        set_reg(CFG_CORE_CLOCK, clk_hz);
        set_reg(CFG_OVF_LIMIT, limit);
        set_reg(CFG_COIL_DWELL, dwell);
        set_reg(CFG_FIRST_TDC, tdc1);
        set_reg(CFG_SECOND_TDC, tdc2);
        cfg_we <= 1'b0;
    endtask

    // One tooth of the given period: as many wraps as allowed, then the capture
    task automatic send_period(input logic [31:0] period);
        int unsigned wraps;
        logic [31:0] rest;
        cgd_req_t r;
        wraps = period / 65535;
        if (wraps > board.stop_limit)
            wraps = 32'(board.stop_limit);
        repeat (wraps) send_req(random_req(REQ_OVERFLOW));
        rest = period - wraps * 65535;
        r = random_req(REQ_CAPTURE);
        r.capture_ticks = (rest > 32'hFFFF) ? 16'hFFFF : rest[15:0];
        send_req(r);
    endtask

    // A few even teeth followed by a long one near the gap ratio
    task automatic run_wheel();
        int unsigned p_max;
        int unsigned base;
        int unsigned tooth;
        int unsigned pick;
        longint unsigned gap_len;
        p_max = (board.stop_limit + 1) * 65535 / 4;
        if (p_max > 200000)
            p_max = 200000;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            base = $urandom_range(1, 60);
        else if (pick < 8)
            base = $urandom_range(60, 16000);
        else
            base = $urandom_range(16000, p_max);
        tooth = base;
        repeat ($urandom_range(1, 5))
        begin
            tooth = base + $urandom_range(0, base / 8) - base / 16;
            if (tooth == 0)
                tooth = 1;
            send_period(tooth);
        end
        case ($urandom_range(0, 9))
            0: gap_len = (64'(tooth) * 5 + 1) / 2;   // at the low ratio bound
            1: gap_len = (64'(tooth) * 7 - 1) / 2;   // just under the high bound
            2: gap_len = (64'(tooth) * 7 + 1) / 2;   // at the high bound: no gap
            3: gap_len = (64'(tooth) * 5 - 1) / 2;   // just under the low bound: no gap
            default: gap_len = 64'(tooth) * $urandom_range(26, 34) / 10;
        endcase
        send_period(gap_len[31:0]);
    endtask

    // Result side: random stall before each result, some calm stretches
    initial
    begin
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (n_results % 32 == 0)
                quiet_rx = ($urandom_range(0, 3) == 0);
            hold = quiet_rx ? 0 : $urandom_range(0, 7);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            board.check_result(rsp_data);
            n_results++;
        end
    end

    // Stimulus
    initial
    begin
        int pick;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gap ratio bounds, restart flag, saturated rates, zero periods
        send_req(pack_req(REQ_CAPTURE, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd1000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd1000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd3000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd1000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd2500, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_req(pack_req(REQ_CAPTURE, 16'd1000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd3500, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd1000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd2499, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd1000, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd3499, 8'd128, 32'd5000, 32'd7000));
        send_req(pack_req(REQ_CAPTURE, 16'd1, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'hFFFF, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd0, 8'd0, 32'd0, 32'd0));

        // wraps into the period, then a stop report with a tight limit
        program_regs(CORE_CLOCK_RESET, 32'd2, COIL_DWELL_RESET, 32'(FIRST_TDC_RESET),
                     32'(SECOND_TDC_RESET));
        send_req(pack_req(REQ_OVERFLOW, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_req(pack_req(REQ_CAPTURE, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_OVERFLOW, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_OVERFLOW, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_OVERFLOW, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_OVERFLOW, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_OVERFLOW, 16'd0, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'hFFFF, 8'd0, 32'd0, 32'd0));
        send_req(pack_req(REQ_CAPTURE, 16'd21845, 8'd10, 32'd100, 32'd100));

        // random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: program_regs($urandom, 32'd3, $urandom, 32'd63, 32'd0);
                1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF);
                2: program_regs(32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
                3: program_regs(32'd1, $urandom_range(0, 12), $urandom_range(0, 500000),
                                $urandom_range(0, 63), $urandom_range(0, 63));
                default: program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            while (n_sent < OPENING_ITEMS + (ph + 1) * PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    run_wheel();
                else if (pick < 17)
                    repeat ($urandom_range(1, 3))
                        send_req(random_req(1'($urandom_range(0, 1))));
                else if (pick < 19)
                begin
                    // enough wraps to stop the engine when the limit is low
                    if (board.stop_limit < 12)
                        repeat (board.stop_limit + 1) send_req(random_req(REQ_OVERFLOW));
                    else
                        repeat ($urandom_range(1, 4)) send_req(random_req(REQ_OVERFLOW));
                end
                else
                    wait_drained();
            end
        end

        wait_drained();
        repeat (LATENCY_GUARD) @(posedge clk);
        $display("sent %0d requests over several register settings, checked %0d results",
                 n_sent, n_results);
        $display("%0d gap schedules, %0d tooth rate updates, %0d stop reports, %0d mismatches",
                 board.n_bursts, board.n_rates, board.n_stops, board.errors);
        if (board.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
